// ===== rtl/vsrt_pkg.sv =====
// Package: types, constants, sine table and fixed-point helpers for the vertex transform.
package vsrt_pkg;

    localparam int SINE_TABLE_BITS = 10;
    localparam int QUARTER         = 1 << (SINE_TABLE_BITS - 2);
    localparam int J_W             = SINE_TABLE_BITS - 1;
    localparam int COEF_W          = 16;
    localparam int QTBL_W          = (QUARTER + 1) * COEF_W;
    localparam int PIPE_DEPTH      = 9;
    localparam int ADDR_W          = 5;

    localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611B;

    typedef enum logic [2:0] {
        REG_SCALE    = 3'd0,
        REG_ANGLE_X  = 3'd1,
        REG_ANGLE_Y  = 3'd2,
        REG_ANGLE_Z  = 3'd3,
        REG_OFFSET_X = 3'd4,
        REG_OFFSET_Y = 3'd5,
        REG_OFFSET_Z = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } t_vec;

    typedef struct packed {
        logic signed [COEF_W-1:0] sin_v;
        logic signed [COEF_W-1:0] cos_v;
    } t_sc;

    typedef struct packed {
        t_sc ax;
        t_sc ay;
        t_sc az;
    } t_trig;

    typedef struct packed {
        logic signed [31:0] scale;
        t_vec               offset;
    } t_cfg;

    // (a * b) >> 62 for unsigned Q62 operands
    function automatic logic [63:0] f_mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] m;
        m = {64'd0, a} * {64'd0, b};
        return m[125:62];
    endfunction

    // sine of x in Q62, 0 <= x <= pi/2, Taylor series
    function automatic logic [63:0] f_sine_q62(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        int          k;
        x2   = f_mul_q62(x, x);
        term = x;
        sum  = x;
        for (k = 1; k < 40 && term != 64'd0; k++) begin
            term = f_mul_q62(term, x2) / 64'((2 * k) * (2 * k + 1));
            if (k[0]) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        return sum;
    endfunction

    // quarter-wave table, Q2.14, evaluated at elaboration
    function automatic logic [QTBL_W-1:0] f_build_qsine();
        logic [QTBL_W-1:0] tbl;
        logic [63:0]       step;
        logic [63:0]       rem;
        logic [63:0]       x;
        logic [63:0]       s;
        int                j;
        tbl  = '0;
        step = HALF_PI_Q62 / QUARTER;
        rem  = HALF_PI_Q62 % QUARTER;
        for (j = 0; j <= QUARTER; j++) begin
            x = step * 64'(j) + (rem * 64'(j)) / QUARTER;
            s = f_sine_q62(x);
            s = (s + (64'd1 << 47)) >> 48;
            tbl[j*COEF_W +: COEF_W] = s[COEF_W-1:0];
        end
        return tbl;
    endfunction

    localparam logic [QTBL_W-1:0] QSINE_TBL = f_build_qsine();

    function automatic logic signed [COEF_W-1:0] f_tbl(
        input logic [SINE_TABLE_BITS-1:0] idx
    );
        logic [1:0]                 q;
        logic [SINE_TABLE_BITS-3:0] r;
        logic [J_W-1:0]             j;
        logic signed [COEF_W-1:0]   v;
        q = idx[SINE_TABLE_BITS-1 -: 2];
        r = idx[SINE_TABLE_BITS-3:0];
        j = q[0] ? (J_W'(QUARTER) - J_W'(r)) : J_W'(r);
        v = QSINE_TBL[j*COEF_W +: COEF_W];
        return q[1] ? -v : v;
    endfunction

    function automatic t_sc f_sincos(input logic [15:0] angle);
        logic [SINE_TABLE_BITS-1:0] idx;
        t_sc                        sc;
        idx      = angle[15 -: SINE_TABLE_BITS];
        sc.sin_v = f_tbl(idx);
        sc.cos_v = f_tbl(idx + SINE_TABLE_BITS'(QUARTER));
        return sc;
    endfunction

    function automatic logic signed [31:0] f_sat32(input logic signed [47:0] v);
        if (v > 48'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (v < -48'sd2147483648) begin
            return 32'sh80000000;
        end else begin
            return v[31:0];
        end
    endfunction

endpackage

// ===== rtl/vsrt_in_if.sv =====
// Input channel: one vertex word with valid/ready.
interface vsrt_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;

    modport source (output valid, output pos_x, output pos_y, output pos_z, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input pos_z, output ready);
endinterface

// ===== rtl/vsrt_out_if.sv =====
// Output channel: one transformed vertex word with valid/ready.
interface vsrt_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;

    modport source (output valid, output out_x, output out_y, output out_z, input ready);
    modport sink   (input valid, input out_x, input out_y, input out_z, output ready);
endinterface

// ===== rtl/vsrt_regs.sv =====
// APB register file with registered sine/cosine lookup per axis.
module vsrt_regs
    import vsrt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output t_cfg              o_cfg,
    output t_trig             o_trig
);

    logic [15:0] r_angle_x;
    logic [15:0] r_angle_y;
    logic [15:0] r_angle_z;
    t_cfg        r_cfg;
    t_trig       r_trig;
    t_reg_idx    w_idx;
    logic        w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign w_wr   = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.scale    <= 32'sd65536;
            r_cfg.offset   <= '0;
            r_angle_x      <= '0;
            r_angle_y      <= '0;
            r_angle_z      <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_SCALE:    r_cfg.scale    <= pwdata;
                REG_ANGLE_X:  r_angle_x      <= pwdata[15:0];
                REG_ANGLE_Y:  r_angle_y      <= pwdata[15:0];
                REG_ANGLE_Z:  r_angle_z      <= pwdata[15:0];
                REG_OFFSET_X: r_cfg.offset.x <= pwdata;
                REG_OFFSET_Y: r_cfg.offset.y <= pwdata;
                REG_OFFSET_Z: r_cfg.offset.z <= pwdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_trig.ax <= f_sincos(r_angle_x);
        r_trig.ay <= f_sincos(r_angle_y);
        r_trig.az <= f_sincos(r_angle_z);
    end

    always_comb begin
        unique case (w_idx)
            REG_SCALE:    prdata = r_cfg.scale;
            REG_ANGLE_X:  prdata = {16'd0, r_angle_x};
            REG_ANGLE_Y:  prdata = {16'd0, r_angle_y};
            REG_ANGLE_Z:  prdata = {16'd0, r_angle_z};
            REG_OFFSET_X: prdata = r_cfg.offset.x;
            REG_OFFSET_Y: prdata = r_cfg.offset.y;
            REG_OFFSET_Z: prdata = r_cfg.offset.z;
            default:      prdata = '0;
        endcase
    end

    assign o_cfg  = r_cfg;
    assign o_trig = r_trig;

endmodule

// ===== rtl/vsrt_scale.sv =====
// Two-stage uniform scale: 32x32 multiply, then shift and saturate.
module vsrt_scale
    import vsrt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  t_vec               i_pos,
    input  logic signed [31:0] i_scale,
    output logic               o_valid,
    input  logic               i_ready,
    output t_vec               o_vec
);

    logic               r1_v;
    logic signed [63:0] r1_px;
    logic signed [63:0] r1_py;
    logic signed [63:0] r1_pz;
    logic               r2_v;
    t_vec               r2_vec;
    logic               w_en1;
    logic               w_en2;

    assign w_en2   = ~r2_v | i_ready;
    assign w_en1   = ~r1_v | w_en2;
    assign o_ready = w_en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
        end else begin
            if (w_en1) begin
                r1_v <= i_valid;
            end
            if (w_en2) begin
                r2_v <= r1_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r1_px <= i_pos.x * i_scale;
            r1_py <= i_pos.y * i_scale;
            r1_pz <= i_pos.z * i_scale;
        end
        if (w_en2) begin
            r2_vec.x <= f_sat32($signed(r1_px[63:16]));
            r2_vec.y <= f_sat32($signed(r1_py[63:16]));
            r2_vec.z <= f_sat32($signed(r1_pz[63:16]));
        end
    end

    assign o_valid = r2_v;
    assign o_vec   = r2_vec;

endmodule

// ===== rtl/vsrt_rot.sv =====
// Two-stage plane rotation: f = a*c - b*s, s = a*s + b*c; third coordinate rides along.
module vsrt_rot
    import vsrt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [31:0] i_a,
    input  logic signed [31:0] i_b,
    input  logic signed [31:0] i_p,
    input  t_sc                i_sc,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_f,
    output logic signed [31:0] o_s,
    output logic signed [31:0] o_p
);

    logic               r1_v;
    logic signed [47:0] r1_ac;
    logic signed [47:0] r1_bs;
    logic signed [47:0] r1_as;
    logic signed [47:0] r1_bc;
    logic signed [31:0] r1_p;
    logic               r2_v;
    logic signed [31:0] r2_f;
    logic signed [31:0] r2_s;
    logic signed [31:0] r2_p;
    logic signed [47:0] w_f;
    logic signed [47:0] w_s;
    logic               w_en1;
    logic               w_en2;

    assign w_en2   = ~r2_v | i_ready;
    assign w_en1   = ~r1_v | w_en2;
    assign o_ready = w_en1;

    // each product is truncated on its own before the row sum
    assign w_f = (r1_ac >>> 14) - (r1_bs >>> 14);
    assign w_s = (r1_as >>> 14) + (r1_bc >>> 14);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
        end else begin
            if (w_en1) begin
                r1_v <= i_valid;
            end
            if (w_en2) begin
                r2_v <= r1_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r1_ac <= i_a * i_sc.cos_v;
            r1_bs <= i_b * i_sc.sin_v;
            r1_as <= i_a * i_sc.sin_v;
            r1_bc <= i_b * i_sc.cos_v;
            r1_p  <= i_p;
        end
        if (w_en2) begin
            r2_f <= f_sat32(w_f);
            r2_s <= f_sat32(w_s);
            r2_p <= r1_p;
        end
    end

    assign o_valid = r2_v;
    assign o_f     = r2_f;
    assign o_s     = r2_s;
    assign o_p     = r2_p;

endmodule

// ===== rtl/vsrt_xlate.sv =====
// Output stage: add offset, saturate, hold the result word for the sink.
module vsrt_xlate
    import vsrt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_vec i_vec,
    input  t_vec i_offset,
    vsrt_out_if.source o_out
);

    logic               r_v;
    t_vec               r_vec;
    logic signed [47:0] w_x;
    logic signed [47:0] w_y;
    logic signed [47:0] w_z;
    logic               w_en;

    assign w_en    = ~r_v | o_out.ready;
    assign o_ready = w_en;

    assign w_x = i_vec.x + i_offset.x;
    assign w_y = i_vec.y + i_offset.y;
    assign w_z = i_vec.z + i_offset.z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (w_en) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_vec.x <= f_sat32(w_x);
            r_vec.y <= f_sat32(w_y);
            r_vec.z <= f_sat32(w_z);
        end
    end

    assign o_out.valid = r_v;
    assign o_out.out_x = r_vec.x;
    assign o_out.out_y = r_vec.y;
    assign o_out.out_z = r_vec.z;

endmodule

// ===== rtl/vertex_scale_rotate_translate.sv =====
// Top level: scale, rotate X/Y/Z and translate one Q16.16 vertex per word.
//
// Takes one vertex word per clock unless the sink stalls the pipeline, and returns one
// transformed word per vertex. The pipeline has nine register stages (scale multiply,
// scale shift/saturate, multiply and sum for each of the three rotations, offset add);
// each rotation uses four 32x16 multipliers, the scale three 32x32. Each stage stalls
// on its own, so bubbles are squeezed out and up to nine words can be in flight. Sine
// and cosine come from a quarter-wave Q2.14 table and are re-registered from the angle
// registers every cycle, in the cycle after an angle write; write configuration only
// while the pipeline is empty. A vertex may be sent in the cycle after the write, since
// it passes the scale multiply and shift/saturate stages before the first rotation.
module vertex_scale_rotate_translate
    import vsrt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    vsrt_in_if.sink           i_in,
    vsrt_out_if.source        o_out
);

    t_cfg  w_cfg;
    t_trig w_trig;
    t_vec  w_pos;

    logic  w_sc_v;
    t_vec  w_sc_vec;
    logic  w_rx_v,  w_rx_rdy;
    logic  w_ry_v,  w_ry_rdy;
    logic  w_rz_v,  w_rz_rdy;
    logic  w_xl_rdy;

    logic signed [31:0] w_rx_y, w_rx_z, w_rx_x;
    logic signed [31:0] w_ry_z, w_ry_x, w_ry_y;
    logic signed [31:0] w_rz_x, w_rz_y, w_rz_z;
    t_vec  w_rot;

    assign w_pos.x = i_in.pos_x;
    assign w_pos.y = i_in.pos_y;
    assign w_pos.z = i_in.pos_z;

    vsrt_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg),
        .o_trig  (w_trig)
    );

    vsrt_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (i_in.ready),
        .i_pos   (w_pos),
        .i_scale (w_cfg.scale),
        .o_valid (w_sc_v),
        .i_ready (w_rx_rdy),
        .o_vec   (w_sc_vec)
    );

    // X: y' = c*y - s*z, z' = s*y + c*z
    vsrt_rot u_rot_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_sc_v),
        .o_ready (w_rx_rdy),
        .i_a     (w_sc_vec.y),
        .i_b     (w_sc_vec.z),
        .i_p     (w_sc_vec.x),
        .i_sc    (w_trig.ax),
        .o_valid (w_rx_v),
        .i_ready (w_ry_rdy),
        .o_f     (w_rx_y),
        .o_s     (w_rx_z),
        .o_p     (w_rx_x)
    );

    // Y: z' = c*z - s*x, x' = s*z + c*x
    vsrt_rot u_rot_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_rx_v),
        .o_ready (w_ry_rdy),
        .i_a     (w_rx_z),
        .i_b     (w_rx_x),
        .i_p     (w_rx_y),
        .i_sc    (w_trig.ay),
        .o_valid (w_ry_v),
        .i_ready (w_rz_rdy),
        .o_f     (w_ry_z),
        .o_s     (w_ry_x),
        .o_p     (w_ry_y)
    );

    // Z: x' = c*x - s*y, y' = s*x + c*y
    vsrt_rot u_rot_z (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_ry_v),
        .o_ready (w_rz_rdy),
        .i_a     (w_ry_x),
        .i_b     (w_ry_y),
        .i_p     (w_ry_z),
        .i_sc    (w_trig.az),
        .o_valid (w_rz_v),
        .i_ready (w_xl_rdy),
        .o_f     (w_rz_x),
        .o_s     (w_rz_y),
        .o_p     (w_rz_z)
    );

    assign w_rot.x = w_rz_x;
    assign w_rot.y = w_rz_y;
    assign w_rot.z = w_rz_z;

    vsrt_xlate u_xlate (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_rz_v),
        .o_ready  (w_xl_rdy),
        .i_vec    (w_rot),
        .i_offset (w_cfg.offset),
        .o_out    (o_out)
    );

endmodule

// ===== rtl/vsrt_checker.sv =====
// Port-level checker for the vertex transform, bound to the top level.
module vsrt_checker
    import vsrt_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_x,
    input logic [31:0] i_out_y,
    input logic [31:0] i_out_z,
    input logic        i_pready
);

    localparam int CNT_W = $clog2(PIPE_DEPTH + 1);

    logic [CNT_W-1:0] r_cnt;
    logic             w_in_acc;
    logic             w_out_acc;

    assign w_in_acc  = i_in_valid & i_in_ready;
    assign w_out_acc = i_out_valid & i_out_ready;

    // words in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (w_in_acc && !w_out_acc) begin
            r_cnt <= r_cnt + 1'b1;
        end else if (w_out_acc && !w_in_acc) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_x)
            && $stable(i_out_y) && $stable(i_out_z))
        else $error("output word changed while stalled");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_cnt != '0)
        else $error("output word without a pending input word");

    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(PIPE_DEPTH))
        else $error("more words in flight than pipeline stages");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("output valid right after reset");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pready)
        else $error("pready low");

endmodule

bind vertex_scale_rotate_translate vsrt_checker u_vsrt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_x     (o_out.out_x),
    .i_out_y     (o_out.out_y),
    .i_out_z     (o_out.out_z),
    .i_pready    (pready)
);

// ===== verif/vertex_scale_rotate_translate_test.sv =====
// Testbench for vertex_scale_rotate_translate: directed and random vertices checked by a predictor.
module vertex_scale_rotate_translate_test;
    import vsrt_pkg::*;

    localparam real QUARTER_TURN_RAD = 1.5707963267948966;
    localparam logic [2:0] REG_UNMAPPED = 3'd7;
    localparam int MAX_WAIT = 8;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_WORDS = 138;

    typedef enum logic [1:0] {
        IDLE_NONE = 2'd0,
        IDLE_SRC  = 2'd1,
        IDLE_SNK  = 2'd2,
        IDLE_BOTH = 2'd3
    } t_idle;

    typedef struct {
        t_vec pos;
        int   gap;
    } t_pending;

    typedef struct packed {
        logic signed [31:0]  scale;
        logic [2:0][15:0]    angle;
        t_vec                offset;
    } t_setting;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    vsrt_in_if  in_if ();
    vsrt_out_if out_if ();

    vertex_scale_rotate_translate i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #4 i_clk = ~i_clk;

    // predictor copy of the registers
    logic signed [31:0] scale_now  = 32'sd65536;
    logic [15:0]        ang_x_now  = '0;
    logic [15:0]        ang_y_now  = '0;
    logic [15:0]        ang_z_now  = '0;
    t_vec               offset_now = '0;

    int       quarter_sine [0:QUARTER];
    t_pending vertex_q [$];
    t_vec     transformed_q [$];
    t_pending head;
    t_idle    idle_mode = IDLE_BOTH;
    logic     in_fire = 1'b0;
    logic     out_fire = 1'b0;
    int       gap_left = -1;
    int       hold_left = 0;
    int       vertices_queued = 0;
    int       vertices_checked = 0;
    int       settings_count = 0;
    int       error_count = 0;

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end
        if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic longint table_coef(input logic [SINE_TABLE_BITS-1:0] idx);
        logic [1:0] quad;
        int         pos;
        longint     mag;
        quad = idx[SINE_TABLE_BITS-1 -: 2];
        pos  = int'(idx[SINE_TABLE_BITS-3:0]);
        mag  = quad[0] ? quarter_sine[QUARTER - pos] : quarter_sine[pos];
        return quad[1] ? -mag : mag;
    endfunction

    // a' = c*a - s*b, b' = s*a + c*b, each product floored on its own
    function automatic void turn_pair(input logic [15:0] angle, inout longint a,
                                      inout longint b);
        logic [SINE_TABLE_BITS-1:0] idx;
        longint                     s;
        longint                     c;
        longint                     na;
        idx = angle[15 -: SINE_TABLE_BITS];
        s   = table_coef(idx);
        c   = table_coef(idx + SINE_TABLE_BITS'(QUARTER));
        na  = clamp32(((a * c) >>> 14) - ((b * s) >>> 14));
        b   = clamp32(((a * s) >>> 14) + ((b * c) >>> 14));
        a   = na;
    endfunction

    function automatic t_vec transform_vertex(input t_vec p);
        longint x;
        longint y;
        longint z;
        t_vec   r;
        x = clamp32((longint'(p.x) * longint'(scale_now)) >>> 16);
        y = clamp32((longint'(p.y) * longint'(scale_now)) >>> 16);
        z = clamp32((longint'(p.z) * longint'(scale_now)) >>> 16);
        turn_pair(ang_x_now, y, z);
        turn_pair(ang_y_now, z, x);
        turn_pair(ang_z_now, x, y);
        r.x = clamp32(x + longint'(offset_now.x));
        r.y = clamp32(y + longint'(offset_now.y));
        r.z = clamp32(z + longint'(offset_now.z));
        return r;
    endfunction

    function automatic void check_field(input string name, input logic signed [31:0] want,
                                        input logic signed [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    // monitor: register writes, accepted vertices and returned words
    always @(posedge i_clk) begin
        in_fire  <= i_rst_n && in_if.valid && in_if.ready;
        out_fire <= i_rst_n && out_if.valid && out_if.ready;
        if (i_rst_n) begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[ADDR_W-1:2])
                    REG_SCALE:    scale_now    = pwdata;
                    REG_ANGLE_X:  ang_x_now    = pwdata[15:0];
                    REG_ANGLE_Y:  ang_y_now    = pwdata[15:0];
                    REG_ANGLE_Z:  ang_z_now    = pwdata[15:0];
                    REG_OFFSET_X: offset_now.x = pwdata;
                    REG_OFFSET_Y: offset_now.y = pwdata;
                    REG_OFFSET_Z: offset_now.z = pwdata;
                    default: ;
                endcase
            end
            if (in_if.valid && in_if.ready) begin
                transformed_q.push_back(
                    transform_vertex({in_if.pos_x, in_if.pos_y, in_if.pos_z}));
            end
            if (out_if.valid && out_if.ready) begin
                vertices_checked++;
                if (transformed_q.size() == 0) begin
                    $error("unexpected word: %0d %0d %0d",
                           out_if.out_x, out_if.out_y, out_if.out_z);
                    error_count++;
                end else begin
                    check_field("out_x", transformed_q[0].x, out_if.out_x);
                    check_field("out_y", transformed_q[0].y, out_if.out_y);
                    check_field("out_z", transformed_q[0].z, out_if.out_z);
                    void'(transformed_q.pop_front());
                end
            end
        end
    end

    // vertex driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!in_if.valid || in_fire) begin
            if (vertex_q.size() == 0) begin
                in_if.valid <= 1'b0;
            end else begin
                if (gap_left < 0) begin
                    gap_left = vertex_q[0].gap;
                end
                if (gap_left > 0) begin
                    gap_left--;
                    in_if.valid <= 1'b0;
                end else begin
                    head = vertex_q.pop_front();
                    gap_left = -1;
                    in_if.valid <= 1'b1;
                    in_if.pos_x <= head.pos.x;
                    in_if.pos_y <= head.pos.y;
                    in_if.pos_z <= head.pos.z;
                end
            end
        end
    end

    // result sink with random stalls
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_fire) begin
                hold_left = (idle_mode == IDLE_SNK || idle_mode == IDLE_BOTH)
                            ? $urandom_range(0, MAX_WAIT) : 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic load_settings(input t_setting cfg);
        reg_write(REG_SCALE, cfg.scale);
        reg_write(REG_ANGLE_X, {16'd0, cfg.angle[0]});
        reg_write(REG_ANGLE_Y, {16'd0, cfg.angle[1]});
        reg_write(REG_ANGLE_Z, {16'd0, cfg.angle[2]});
        reg_write(REG_OFFSET_X, cfg.offset.x);
        reg_write(REG_OFFSET_Y, cfg.offset.y);
        reg_write(REG_OFFSET_Z, cfg.offset.z);
        settings_count++;
        // trig coefficients are re-registered from the angles
        repeat (4) @(negedge i_clk);
    endtask

    task automatic push_vertex(input logic signed [31:0] x, input logic signed [31:0] y,
                               input logic signed [31:0] z);
        t_pending item;
        item.pos = {x, y, z};
        item.gap = (idle_mode == IDLE_SRC || idle_mode == IDLE_BOTH)
                   ? $urandom_range(0, MAX_WAIT) : 0;
        vertex_q.push_back(item);
        vertices_queued++;
    endtask

    task automatic settle();
        while (vertices_checked < vertices_queued) @(negedge i_clk);
        repeat (PIPE_DEPTH + 3) @(negedge i_clk);
    endtask

    function automatic logic signed [31:0] rand_q16();
        logic signed [31:0] v;
        case ($urandom_range(0, 15))
            0:       v = 32'sh7FFFFFFF;
            1:       v = 32'sh80000000;
            2:       v = '0;
            3:       v = -32'sd1;
            default: v = $signed($urandom) >>> $urandom_range(0, 31);
        endcase
        return v;
    endfunction

    function automatic t_setting random_setting();
        t_setting cfg;
        case ($urandom_range(0, 7))
            0:       cfg.scale = 32'sd65536;
            1:       cfg.scale = 32'sh7FFFFFFF;
            2:       cfg.scale = 32'sh80000000;
            3:       cfg.scale = '0;
            default: cfg.scale = $signed($urandom) >>> $urandom_range(12, 31);
        endcase
        for (int a = 0; a < 3; a++) begin
            case ($urandom_range(0, 9))
                0:       cfg.angle[a] = 16'h0000;
                1:       cfg.angle[a] = 16'hFFFF;
                2:       cfg.angle[a] = 16'h4000;
                3:       cfg.angle[a] = 16'h8000;
                default: cfg.angle[a] = 16'($urandom_range(0, 65535));
            endcase
        end
        cfg.offset = {rand_q16(), rand_q16(), rand_q16()};
        return cfg;
    endfunction

    initial begin : stimulus
        i_rst_n      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        in_if.valid  = 1'b0;
        in_if.pos_x  = '0;
        in_if.pos_y  = '0;
        in_if.pos_z  = '0;
        out_if.ready = 1'b0;
        for (int j = 0; j <= QUARTER; j++) begin
            quarter_sine[j] = int'(16384.0 * $sin(QUARTER_TURN_RAD * j / QUARTER));
        end

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (4) @(negedge i_clk);

        // reset values: identity transform
        push_vertex('0, '0, '0);
        push_vertex(32'sh7FFFFFFF, 32'sh80000000, -32'sd1);
        push_vertex(32'sh80000000, 32'sh7FFFFFFF, 32'sd1);
        push_vertex(32'sh00010000, 32'shFFFF0000, 32'sh12345678);
        settle();

        // write to an unmapped index must leave the transform alone
        reg_write(REG_UNMAPPED, 32'hDEADBEEF);
        repeat (4) @(negedge i_clk);
        push_vertex(32'sh00030000, -32'sd5, 32'sd7);
        settle();

        // max scale saturates the first stage; top table index wraps the cosine
        load_settings({32'sh7FFFFFFF, {16'hFFFF, 16'hFFFF, 16'hFFFF},
                       {32'sh7FFFFFFF, 32'sh80000000, -32'sd1}});
        push_vertex(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
        push_vertex(32'sh80000000, 32'sh80000000, 32'sh80000000);
        push_vertex(32'sd1, -32'sd1, '0);
        push_vertex(32'sh00007FFF, -32'sh00008000, 32'sh00000100);
        settle();

        // min scale, quarter-turn multiples
        load_settings({32'sh80000000, {16'hC000, 16'h8000, 16'h4000}, 96'd0});
        push_vertex(32'sh7FFFFFFF, 32'sh80000000, 32'sh00010000);
        push_vertex(-32'sd1, -32'sd1, -32'sd1);
        push_vertex(32'sh00012345, 32'sh40000000, -32'sh40000000);
        settle();

        load_settings({32'sh00008000, {16'h2000, 16'hFFC0, 16'h003F},
                       {32'sh80000000, 32'sh7FFFFFFF, 32'sh00010000}});
        push_vertex(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000);
        push_vertex(32'sh00010000, 32'sh00020000, 32'sh00030000);
        push_vertex(32'sh80000000, '0, 32'sh7FFFFFFF);
        settle();

        load_settings({32'sd0, {16'h1234, 16'hABCD, 16'h5555},
                       {32'sh00010000, -32'sh00020000, 32'sh00000001}});
        push_vertex(32'sh7FFFFFFF, 32'sh80000000, 32'sd5);
        push_vertex(-32'sh00654321, 32'sh00123456, '0);
        settle();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            idle_mode = t_idle'(p % 4);
            load_settings(random_setting());
            repeat (PHASE_WORDS) begin
                push_vertex(rand_q16(), rand_q16(), rand_q16());
            end
            settle();
        end

        if (transformed_q.size() != 0) begin
            $error("%0d expected vertices never returned", transformed_q.size());
            error_count++;
        end
        $display("Checked %0d vertices over %0d register settings, %0d mismatches.",
                 vertices_checked, settings_count, error_count);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin : watchdog
        #4000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
